// ===== rtl/mlcd_pkg.sv =====
// Shared operation codes, register indexes and state types of the memory LCD frame controller.
package mlcd_pkg;

	localparam int MODE_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [MODE_W-1:0] MODE_PIXEL     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HLINE     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_VLINE     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_UPDATE    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_PULL      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_VCOM      = 3'd6;
	localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_VCOM_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALL_CLEAR = 2'd2;

	localparam logic [7:0] VCOM_MASK_RST = 8'h02;
	localparam logic [7:0] UPDATE_RST    = 8'h01;
	localparam logic [7:0] ALL_CLEAR_RST = 8'h04;

	localparam logic [7:0] BYTE_WHITE = 8'hFF;
	localparam logic [7:0] BYTE_ZERO  = 8'h00;

	// Bytes after the command byte in a panel self-clear transfer, minus one
	localparam int CLEAR_TAIL_LAST = 2;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_UPDATE = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_INIT   = 7'b0000010,
		ST_CLEAR  = 7'b0000100,
		ST_PIX_RD = 7'b0001000,
		ST_PIX_WR = 7'b0010000,
		ST_PULL   = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

endpackage

// ===== rtl/memory_lcd_frame_controller_top.sv =====
// Frame controller for a one-bit-per-pixel memory LCD: frame store, drawing and panel byte stream.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  cfg     | in        | cfg_we                | cfg_index, cfg_wdata
//  in      | in        | in_valid / in_stall   | mode, x, y, end_coord, dark
//  out     | out       | out_valid / out_stall | out_byte, last_byte
//
// A horizontal or vertical line does one read and one write of the single frame store port per
// dot; an empty line, or a pull with nothing pending, leaves the sequencer idle; a stream
// data byte takes one store read.
// STORE_DEPTH = PANEL_LINES * 2**max(1, ceil(log2(ceil(DOTS_PER_LINE/8)))) (2048 at defaults).
// After reset a clearing pass writes white to all STORE_DEPTH store bytes with
// in_stall high; config writes are taken as ever.
// A result waits in the output register while out_stall is high; the sequencer holds in
// its emit state until that register is free.
module memory_lcd_frame_controller_top #(
	parameter int PANEL_LINES   = 128,
	parameter int DOTS_PER_LINE = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mlcd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                       cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [mlcd_pkg::MODE_W-1:0]      mode,
	input  logic [7:0]                       x,
	input  logic [7:0]                       y,
	input  logic [7:0]                       end_coord,
	input  logic                             dark,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_byte,
	output logic                             last_byte
);
	import mlcd_pkg::*;

	// Store geometry: each line is padded to a power-of-two number of bytes so that the
	// address is a plain concatenation of line and byte index.
	localparam int LINE_BYTES = (DOTS_PER_LINE + 7) / 8;
	localparam int LBW        = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
	localparam int LINE_W     = $clog2(PANEL_LINES);
	localparam int AW         = LINE_W + LBW;
	localparam int MEM_DEPTH  = PANEL_LINES * (2 ** LBW);
	localparam int LCW        = $clog2(PANEL_LINES + 1);   // line counter, holds PANEL_LINES
	localparam int CW         = $clog2(LINE_BYTES + 2);    // byte slot within a streamed line

	// Control state
	state_t            state_q;
	kind_t             kind_q;
	logic [MODE_W-1:0] mode_q;
	logic              vcom_q;
	logic [LCW-1:0]    line_q;
	logic [CW-1:0]     col_q;
	logic [AW-1:0]     clr_addr_q;
	logic              out_valid_q;

	// Config registers
	logic [7:0] vmask_q;
	logic [7:0] upd_bits_q;
	logic [7:0] aclr_bits_q;

	// Drawing operands and pending result
	logic [7:0] cur_q;
	logic [7:0] end_q;
	logic [7:0] fix_q;
	logic       dark_q;
	logic [7:0] pend_byte_q;
	logic       pend_last_q;
	logic       pend_mem_q;
	logic [7:0] rd_data_q;
	logic [7:0] out_byte_q;
	logic       last_q;

	logic [7:0] frame_mem [MEM_DEPTH];

	logic            in_acc;
	logic            out_free;
	logic            emit_go;
	logic [7:0]      px;
	logic [7:0]      py;
	logic [7:0]      dot;
	logic            pix_ok;
	logic [AW-1:0]   pix_addr;
	logic [7:0]      pix_bit;
	logic [7:0]      pix_wdata;
	logic [CW-1:0]   col_dec;
	logic [AW-1:0]   str_addr;
	logic [8:0]      lnum;
	logic [7:0]      vcom_next_bits;
	logic            draw_done;
	logic            clr_done;
	logic            mem_we;
	logic            mem_re;
	logic [AW-1:0]   mem_waddr;
	logic [AW-1:0]   mem_raddr;
	logic [7:0]      mem_wdata;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_go   = (state_q == ST_EMIT) && out_free;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

	// Shared pixel unit: rotate the coordinate, range check, store address and bit
	always_comb begin
		px = (mode_q == MODE_VLINE) ? fix_q : cur_q;
		py = (mode_q == MODE_VLINE) ? cur_q : fix_q;
		dot = 8'(PANEL_LINES - 1) - py;
		pix_ok = ({1'b0, px} < 9'(PANEL_LINES)) && ({1'b0, py} < 9'(PANEL_LINES))
			&& ({1'b0, dot} < 9'(DOTS_PER_LINE));
		pix_addr = {px[LINE_W-1:0], dot[LBW+2:3]};
		pix_bit = 8'd1 << dot[2:0];
		pix_wdata = dark_q ? (rd_data_q & ~pix_bit) : (rd_data_q | pix_bit);
	end

	// Stream position: slot 0 is the line number, slots 1..LINE_BYTES the line's data
	assign col_dec  = col_q - CW'(1);
	assign str_addr = {line_q[LINE_W-1:0], col_dec[LBW-1:0]};
	assign lnum     = 9'(line_q) + 9'd1;

	// VCOM bits of the command byte after this toggle
	assign vcom_next_bits = vcom_q ? BYTE_ZERO : vmask_q;

	assign draw_done = (mode_q == MODE_PIXEL)
		|| ((mode_q == MODE_HLINE) && (cur_q == end_q))
		|| ((mode_q == MODE_VLINE) && ((cur_q + 8'd1) == end_q));
	assign clr_done = (clr_addr_q == AW'(MEM_DEPTH - 1));

	// Single store port: clear sweep, pixel read-modify-write, stream reads
	always_comb begin
		mem_we    = (state_q == ST_INIT) || (state_q == ST_CLEAR)
			|| ((state_q == ST_PIX_WR) && pix_ok);
		mem_waddr = ((state_q == ST_INIT) || (state_q == ST_CLEAR)) ? clr_addr_q : pix_addr;
		mem_wdata = ((state_q == ST_INIT) || (state_q == ST_CLEAR)) ? BYTE_WHITE : pix_wdata;
		mem_re    = (state_q == ST_PIX_RD) || (state_q == ST_PULL);
		mem_raddr = (state_q == ST_PULL) ? str_addr : pix_addr;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= frame_mem[mem_raddr];
		end
	end

	// Output register payload: load when the emit state hands over
	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_byte_q <= pend_mem_q ? rd_data_q : pend_byte_q;
			last_q     <= pend_last_q;
		end
	end

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmask_q     <= VCOM_MASK_RST;
			upd_bits_q  <= UPDATE_RST;
			aclr_bits_q <= ALL_CLEAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VCOM_MASK: vmask_q     <= cfg_wdata;
				CFG_UPDATE:    upd_bits_q  <= cfg_wdata;
				CFG_ALL_CLEAR: aclr_bits_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			kind_q      <= KIND_NONE;
			mode_q      <= MODE_PIXEL;
			vcom_q      <= 1'b0;
			line_q      <= '0;
			col_q       <= '0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			end_q       <= '0;
			fix_q       <= '0;
			dark_q      <= 1'b0;
			pend_byte_q <= '0;
			pend_last_q <= 1'b0;
			pend_mem_q  <= 1'b0;
		end else begin
			// Fill the output register from the emit state, drop it once it is taken
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						mode_q     <= mode;
						pend_mem_q <= 1'b0;
						case (mode)
							MODE_PIXEL: begin
								cur_q   <= x;
								fix_q   <= y;
								dark_q  <= dark;
								state_q <= ST_PIX_RD;
							end
							MODE_HLINE: begin
								cur_q  <= x;
								fix_q  <= y;
								end_q  <= end_coord;
								dark_q <= 1'b1;
								if (end_coord >= x) begin
									state_q <= ST_PIX_RD;
								end
							end
							MODE_VLINE: begin
								cur_q  <= y;
								fix_q  <= x;
								end_q  <= end_coord;
								dark_q <= 1'b1;
								if (end_coord > y) begin
									state_q <= ST_PIX_RD;
								end
							end
							MODE_CLEAR: begin
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end
							MODE_UPDATE: begin
								kind_q      <= KIND_UPDATE;
								line_q      <= '0;
								col_q       <= '0;
								vcom_q      <= !vcom_q;
								pend_byte_q <= upd_bits_q | vcom_next_bits;
								pend_last_q <= 1'b0;
								state_q     <= ST_EMIT;
							end
							MODE_VCOM: begin
								kind_q      <= KIND_NONE;
								line_q      <= '0;
								col_q       <= '0;
								vcom_q      <= !vcom_q;
								pend_byte_q <= vcom_next_bits;
								pend_last_q <= 1'b1;
								state_q     <= ST_EMIT;
							end
							MODE_CLEAR_ALL: begin
								kind_q      <= KIND_CLEAR;
								line_q      <= '0;
								col_q       <= '0;
								vcom_q      <= !vcom_q;
								pend_byte_q <= aclr_bits_q | vcom_next_bits;
								pend_last_q <= 1'b0;
								clr_addr_q  <= '0;
								state_q     <= ST_CLEAR;
							end
							MODE_PULL: begin
								case (kind_q)
									KIND_CLEAR: begin
										pend_byte_q <= BYTE_ZERO;
										state_q     <= ST_EMIT;
										if (col_q == CW'(CLEAR_TAIL_LAST)) begin
											pend_last_q <= 1'b1;
											kind_q      <= KIND_NONE;
											col_q       <= '0;
										end else begin
											pend_last_q <= 1'b0;
											col_q       <= col_q + CW'(1);
										end
									end
									KIND_UPDATE: begin
										if (line_q == LCW'(PANEL_LINES)) begin
											// Trailing zero closes the frame
											pend_byte_q <= BYTE_ZERO;
											pend_last_q <= 1'b1;
											kind_q      <= KIND_NONE;
											line_q      <= '0;
											col_q       <= '0;
											state_q     <= ST_EMIT;
										end else if (col_q == '0) begin
											pend_byte_q <= lnum[7:0];
											pend_last_q <= 1'b0;
											col_q       <= CW'(1);
											state_q     <= ST_EMIT;
										end else if (col_q == CW'(LINE_BYTES + 1)) begin
											pend_byte_q <= BYTE_ZERO;
											pend_last_q <= 1'b0;
											col_q       <= '0;
											line_q      <= line_q + LCW'(1);
											state_q     <= ST_EMIT;
										end else begin
											state_q <= ST_PULL;
										end
									end
									default: ;
								endcase
							end
							default: ;
						endcase
					end
				end
				ST_INIT: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_done) begin
						state_q <= (mode_q == MODE_CLEAR_ALL) ? ST_EMIT : ST_IDLE;
					end
				end
				ST_PIX_RD: begin
					state_q <= ST_PIX_WR;
				end
				ST_PIX_WR: begin
					if (draw_done) begin
						state_q <= ST_IDLE;
					end else begin
						cur_q   <= cur_q + 8'd1;
						state_q <= ST_PIX_RD;
					end
				end
				ST_PULL: begin
					col_q       <= col_q + CW'(1);
					pend_mem_q  <= 1'b1;
					pend_last_q <= 1'b0;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_none_home: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == KIND_NONE) |-> ((line_q == '0) && (col_q == '0)))
		else $error("stream counters not home with no transfer pending");

	a_clear_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == KIND_CLEAR) |-> ((line_q == '0) && (col_q <= CW'(CLEAR_TAIL_LAST))))
		else $error("self-clear transfer position out of range");

	a_update_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == KIND_UPDATE)
		|-> ((line_q <= LCW'(PANEL_LINES)) && (col_q <= CW'(LINE_BYTES + 1))))
		else $error("update transfer position out of range");

	a_vcom_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && ((mode == MODE_UPDATE) || (mode == MODE_VCOM) || (mode == MODE_CLEAR_ALL)))
		|=> (vcom_q != $past(vcom_q)))
		else $error("VCOM did not toggle on a command");

	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_INIT) || (state_q == ST_CLEAR) || (state_q == ST_PIX_WR)))
		else $error("frame store written outside clear or pixel write");
`endif

endmodule
